FILE: rtl/core/selective_repeat_receiver_defines.svh
// Assertion macros shared by the selective-repeat receiver RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

// Checked only outside reset.
`define SRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SRR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/srr_pkg.sv
// Package for the selective-repeat receiver: constants, beat types, FSM states.
// No dependencies; used by every module in rtl/core.
package srr_pkg;

    localparam int SEQ_BITS       = 8;
    localparam int SEQ_MOD        = 1 << SEQ_BITS;
    localparam int LEN_BITS       = 11;
    localparam int HANDLE_BITS    = 16;
    localparam int WIN_BITS       = 5;
    localparam int MAX_PAYLOAD    = 1024;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(8);

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic [SEQ_BITS-1:0]    frame_seq;
        logic [LEN_BITS-1:0]    payload_length;
        logic [HANDLE_BITS-1:0] payload_handle;
        logic                   frame_corrupt;
    } item_t;

    typedef struct packed {
        logic                   result_kind;
        logic [SEQ_BITS-1:0]    result_seq;
        logic [LEN_BITS-1:0]    out_length;
        logic [HANDLE_BITS-1:0] out_handle;
        logic                   end_of_file;
        logic                   stream_done;
        logic                   last_result;
    } result_t;

    // Contents of one reorder slot as it moves down the chain.
    typedef struct packed {
        logic                   held;
        logic [LEN_BITS-1:0]    length;
        logic [HANDLE_BITS-1:0] handle;
    } slot_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                   shift;
        logic                   write;
        logic [SEQ_BITS-1:0]    wr_offset;
        logic [LEN_BITS-1:0]    wr_length;
        logic [HANDLE_BITS-1:0] wr_handle;
    } chain_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_RELEASE,
        ST_ACK
    } state_t;

endpackage

FILE: rtl/core/srr_cell.sv
// One reorder slot of the receive window; cell CELL_IDX holds offset CELL_IDX from the base.
// Depends on srr_pkg.
module srr_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  srr_pkg::chain_ctl_t ctl,
    input  srr_pkg::slot_t      upper,
    output srr_pkg::slot_t      slot
);

    logic                               held_reg;
    logic [srr_pkg::LEN_BITS-1:0]       length_reg;
    logic [srr_pkg::HANDLE_BITS-1:0]    handle_reg;
    logic                               hit;

    assign hit = ctl.write && !held_reg && (ctl.wr_offset == srr_pkg::SEQ_BITS'(CELL_IDX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            held_reg <= upper.held;
        end
        else if (hit)
        begin
            held_reg <= 1'b1;
        end
    end

    // Take the neighbor's slot on a release; a duplicate never overwrites.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            length_reg <= upper.length;
            handle_reg <= upper.handle;
        end
        else if (hit)
        begin
            length_reg <= ctl.wr_length;
            handle_reg <= ctl.wr_handle;
        end
    end

    assign slot.held   = held_reg;
    assign slot.length = length_reg;
    assign slot.handle = handle_reg;

endmodule

FILE: rtl/core/srr_ctrl.sv
// Window controller: classifies frames, finds end-of-file runs, sequences deliveries.
// Depends on srr_pkg and selective_repeat_receiver_defines.svh.
`include "selective_repeat_receiver_defines.svh"

module srr_ctrl #(
    parameter int MAX_WINDOW = srr_pkg::MAX_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  srr_pkg::item_t                item,
    input  logic                          cfg_we,
    input  logic [srr_pkg::WIN_BITS-1:0]  cfg_wdata,
    input  logic [MAX_WINDOW-1:0]         held_vec,
    input  logic [MAX_WINDOW-1:0]         eof_vec,
    input  srr_pkg::slot_t                head,
    output srr_pkg::chain_ctl_t           ctl,
    output logic                          result_valid,
    output srr_pkg::result_t              result
);

    localparam int W_W     = srr_pkg::SEQ_BITS + 1;
    localparam int HALF    = srr_pkg::SEQ_MOD / 2;
    localparam int WIN_CAP = (MAX_WINDOW < HALF) ? MAX_WINDOW : HALF;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);

    srr_pkg::state_t                    state_reg, state_next;
    logic [srr_pkg::SEQ_BITS-1:0]       base_reg, base_next;
    logic                               finished_reg, finished_next;
    logic [srr_pkg::WIN_BITS-1:0]       window_size_reg;
    logic [srr_pkg::SEQ_BITS-1:0]       seq_reg;
    logic [srr_pkg::LEN_BITS-1:0]       len_reg;
    logic [srr_pkg::HANDLE_BITS-1:0]    handle_reg;

    logic [W_W-1:0]                     win_eff;
    logic [srr_pkg::SEQ_BITS-1:0]       offset;
    logic [W_W-1:0]                     dist_back;
    logic                               in_window;
    logic                               behind;
    logic [CNT_W-1:0]                   first_empty;
    logic [CNT_W-1:0]                   first_eof;
    logic                               eof_in_run;
    logic                               accept;

    assign busy   = (state_reg != srr_pkg::ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= srr_pkg::ST_IDLE;
            base_reg        <= '0;
            finished_reg    <= 1'b0;
            window_size_reg <= srr_pkg::WINDOW_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            finished_reg <= finished_next;
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
        end
    end

    // Hold the frame header; clamp oversized lengths on the way in.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg    <= item.frame_seq;
            handle_reg <= item.payload_handle;
            if (item.payload_length > srr_pkg::LEN_BITS'(srr_pkg::MAX_PAYLOAD))
            begin
                len_reg <= srr_pkg::LEN_BITS'(srr_pkg::MAX_PAYLOAD);
            end
            else
            begin
                len_reg <= item.payload_length;
            end
        end
    end

    // Effective window and frame position relative to the base.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = W_W'(1);
        end
        else if (W_W'(window_size_reg) > W_W'(WIN_CAP))
        begin
            win_eff = W_W'(WIN_CAP);
        end
        else
        begin
            win_eff = W_W'(window_size_reg);
        end
        offset    = seq_reg - base_reg;
        dist_back = W_W'(srr_pkg::SEQ_MOD) - W_W'(offset);
        in_window = W_W'(offset) < win_eff;
        behind    = !in_window && (dist_back <= win_eff);
    end

    // An end-of-file slot gets released this beat run if it sits before the first gap.
    always_comb
    begin
        first_empty = CNT_W'(MAX_WINDOW);
        first_eof   = CNT_W'(MAX_WINDOW);
        for (int j = MAX_WINDOW - 1; j >= 0; j--)
        begin
            if (!held_vec[j])
            begin
                first_empty = CNT_W'(j);
            end
            if (held_vec[j] && eof_vec[j])
            begin
                first_eof = CNT_W'(j);
            end
        end
        eof_in_run = first_eof < first_empty;
    end

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        finished_next = finished_reg;

        ctl.shift     = 1'b0;
        ctl.write     = 1'b0;
        ctl.wr_offset = offset;
        ctl.wr_length = len_reg;
        ctl.wr_handle = handle_reg;

        result_valid       = 1'b0;
        result.result_kind = srr_pkg::KIND_ACK;
        result.result_seq  = seq_reg;
        result.out_length  = '0;
        result.out_handle  = '0;
        result.end_of_file = 1'b0;
        result.stream_done = finished_reg;
        result.last_result = 1'b1;

        unique case (state_reg)
            srr_pkg::ST_IDLE:
            begin
                // Drop corrupt frames at the door.
                if (accept && !item.frame_corrupt)
                begin
                    state_next = srr_pkg::ST_CHECK;
                end
            end
            srr_pkg::ST_CHECK:
            begin
                if (in_window)
                begin
                    ctl.write  = 1'b1;
                    state_next = srr_pkg::ST_SCAN;
                end
                else if (behind)
                begin
                    state_next = srr_pkg::ST_ACK;
                end
                else
                begin
                    state_next = srr_pkg::ST_IDLE;
                end
            end
            srr_pkg::ST_SCAN:
            begin
                finished_next = finished_reg || eof_in_run;
                state_next    = srr_pkg::ST_RELEASE;
            end
            srr_pkg::ST_RELEASE:
            begin
                result_valid = 1'b1;
                if (head.held)
                begin
                    result.result_kind = srr_pkg::KIND_DELIVER;
                    result.result_seq  = base_reg;
                    result.out_length  = head.length;
                    result.out_handle  = head.handle;
                    result.end_of_file = (head.length == '0);
                    result.last_result = 1'b0;
                    ctl.shift          = 1'b1;
                    base_next          = base_reg + 1'b1;
                    if (head.length == '0)
                    begin
                        state_next = srr_pkg::ST_ACK;
                    end
                end
                else
                begin
                    // Gap at the base: acknowledge and finish.
                    state_next = srr_pkg::ST_IDLE;
                end
            end
            srr_pkg::ST_ACK:
            begin
                result_valid = 1'b1;
                state_next   = srr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = srr_pkg::ST_IDLE;
            end
        endcase
    end

    `SRR_ASSERT(a_last_ends_item, result_valid && result.last_result |=> !busy, "busy after last result")
    `SRR_ASSERT(a_result_while_busy, result_valid |-> busy, "result outside an item")
    `SRR_ASSERT(a_eof_marks_done, result_valid && result.result_kind == srr_pkg::KIND_DELIVER && result.end_of_file |-> result.stream_done, "end-of-file delivered without done")
    `SRR_ASSERT_ALWAYS(a_finished_sticks, rst_n && finished_reg |=> !rst_n || finished_reg, "finished flag cleared")

endmodule

FILE: rtl/core/selective_repeat_receiver.sv
// Top level of the selective-repeat ARQ receiver reorder engine.
// Depends on srr_pkg, srr_cell and srr_ctrl.
//
// Usage:
//   Input channel: drive item and raise start; the header is taken at a rising
//   edge where start is high and busy is low. Corrupt headers are taken and
//   dropped at once, and busy stays low.
//   Result channel: each beat is on result for one cycle with result_valid high.
//   The receiver cannot stall, so the block never waits on it. The last beat of
//   an item has last_result set.
//   Configuration: cfg_we writes cfg_wdata into the window size; write only
//   while busy is low.
// Sequence:
//   An accepted header is classified first; a header inside the window is
//   then written into its slot and the window scanned, followed by one in-order
//   delivery per cycle (up to MAX_WINDOW), and the item ends with an
//   acknowledgement beat. A header behind the window is answered with an
//   acknowledgement only; one ahead of it is dropped without a result. The
//   release loop walks the slot chain one slot per cycle.
// Reset: rst_n clears the window base, every held slot, the finished flag and
//   sets the window size to 8; the block is ready in the first cycle after it.
module selective_repeat_receiver #(
    parameter int MAX_WINDOW = srr_pkg::MAX_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  srr_pkg::item_t                item,
    input  logic                          cfg_we,
    input  logic [srr_pkg::WIN_BITS-1:0]  cfg_wdata,
    output logic                          result_valid,
    output srr_pkg::result_t              result
);

    srr_pkg::chain_ctl_t    ctl;
    srr_pkg::slot_t         chain [MAX_WINDOW+1];
    logic [MAX_WINDOW-1:0]  held_vec;
    logic [MAX_WINDOW-1:0]  eof_vec;

    // Past the top cell the window is always empty.
    assign chain[MAX_WINDOW] = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        srr_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .upper (chain[i+1]),
            .slot  (chain[i])
        );

        assign held_vec[i] = chain[i].held;
        assign eof_vec[i]  = (chain[i].length == '0);
    end

    srr_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .held_vec     (held_vec),
        .eof_vec      (eof_vec),
        .head         (chain[0]),
        .ctl          (ctl),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
